>>> sv/sem_pkg.sv
// Package for the Sobel edge magnitude block: field widths, register indexes,
// reset values and the beat structures handed along the pipeline.
// No dependencies; every other file imports it.
package sem_pkg;

  localparam int SEM_MAX_WIDTH = 1024;

  localparam int PIX_W     = 8;
  localparam int FW_W      = 11;
  localparam int FH_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_COL_W = 10;
  localparam int GRAD_W    = 10;
  localparam int SQ_W      = 2 * GRAD_W;
  localparam int ENERGY_W  = SQ_W + 1;
  localparam int RAD_W     = 16;
  localparam int ROOT_W    = 8;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SQRT_STEPS = RAD_W / 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;
  localparam int MIN_DIM = 3;

  localparam logic [ROOT_W-1:0] MAG_SAT = 8'd255;

  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic [FH_W-1:0]      row;
    logic [OUT_COL_W-1:0] col;
  } meta_t;

  typedef struct packed {
    logic              valid;
    meta_t             meta;
    logic              sat;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_beat_t;

endpackage

>>> sv/sem_line_store.sv
// Two line memories holding the two rows above the current one.
// Read data is registered; depends on sem_pkg.
module sem_line_store
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = SEM_MAX_WIDTH,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_pix,
  output logic [PIX_W-1:0] top,
  output logic [PIX_W-1:0] mid
);

  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_r;
  logic [PIX_W-1:0] mid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mid_mem[wr_addr] <= wr_pix;
      top_mem[wr_addr] <= mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_r <= top_mem[rd_addr];
      mid_r <= mid_mem[rd_addr];
    end
  end

  assign top = top_r;
  assign mid = mid_r;

endmodule

>>> sv/sem_window.sv
// 3x3 pixel window and the registered absolute Sobel sums taken from it.
// Depends on sem_pkg.
module sem_window
  import sem_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  meta_t             meta_in,
  input  logic [PIX_W-1:0]  top,
  input  logic [PIX_W-1:0]  mid,
  input  logic [PIX_W-1:0]  pix,
  output logic              valid_out,
  output meta_t             meta_out,
  output logic [GRAD_W-1:0] abs_gx,
  output logic [GRAD_W-1:0] abs_gy
);

  logic [PIX_W-1:0]  win_r [9];
  logic              valid_b_r;
  meta_t             meta_b_r;
  logic              valid_c_r;
  meta_t             meta_c_r;
  logic [GRAD_W-1:0] abs_gx_r;
  logic [GRAD_W-1:0] abs_gy_r;
  logic [GRAD_W-1:0] pos_x;
  logic [GRAD_W-1:0] neg_x;
  logic [GRAD_W-1:0] pos_y;
  logic [GRAD_W-1:0] neg_y;
  logic [GRAD_W-1:0] abs_gx_nxt;
  logic [GRAD_W-1:0] abs_gy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
      valid_b_r <= 1'b0;
      valid_c_r <= 1'b0;
    end else if (en) begin
      valid_b_r <= valid_in;
      valid_c_r <= valid_b_r;
      if (valid_in) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k*3]   <= win_r[k*3+1];
          win_r[k*3+1] <= win_r[k*3+2];
        end
        win_r[2] <= top;
        win_r[5] <= mid;
        win_r[8] <= pix;
      end
    end
  end

  always_comb begin
    pos_x = GRAD_W'(win_r[2]) + {1'b0, win_r[5], 1'b0} + GRAD_W'(win_r[8]);
    neg_x = GRAD_W'(win_r[0]) + {1'b0, win_r[3], 1'b0} + GRAD_W'(win_r[6]);
    pos_y = GRAD_W'(win_r[0]) + {1'b0, win_r[1], 1'b0} + GRAD_W'(win_r[2]);
    neg_y = GRAD_W'(win_r[6]) + {1'b0, win_r[7], 1'b0} + GRAD_W'(win_r[8]);
    abs_gx_nxt = (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
    abs_gy_nxt = (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_b_r <= meta_in;
      meta_c_r <= meta_b_r;
      abs_gx_r <= abs_gx_nxt;
      abs_gy_r <= abs_gy_nxt;
    end
  end

  assign valid_out = valid_c_r;
  assign meta_out  = meta_c_r;
  assign abs_gx    = abs_gx_r;
  assign abs_gy    = abs_gy_r;

endmodule

>>> sv/sem_sqrt_cell.sv
// One cell of the square root chain: retires one root bit per beat and
// hands the partial remainder and root to the next cell. Depends on sem_pkg.
module sem_sqrt_cell
  import sem_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  sqrt_beat_t d_in,
  output sqrt_beat_t d_out
);

  sqrt_beat_t          q_r;
  sqrt_beat_t          q_nxt;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                ge;

  always_comb begin
    rem_sh = {d_in.rem, d_in.rad[RAD_W-1 -: 2]};
    trial  = {2'b00, d_in.root, 2'b01};
    ge     = rem_sh >= trial;
    q_nxt       = d_in;
    q_nxt.rad   = {d_in.rad[RAD_W-3:0], 2'b00};
    q_nxt.rem   = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    q_nxt.root  = {d_in.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

>>> sv/sobel_edge_magnitude.sv
// Sobel edge magnitude over a raster pixel stream, top level.
// Throughput: one pixel beat per cycle; the whole pipeline holds while the
// output register is full and stalled. An accepted beat passes stage A, the
// window stages, D, E, the 8-cell square root chain and the output register.
// Reset (synchronous, active low) clears counters, window, valid bits and
// loads the frame registers with 640 x 480; line memories are not cleared.
module sobel_edge_magnitude
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = SEM_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FH_W-1:0]      out_row,
  output logic [OUT_COL_W-1:0] out_col,
  output logic [ROOT_W-1:0]    out_edge_magnitude,
  output logic                 out_frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  logic [FW_W-1:0]   frame_width_r;
  logic [FH_W-1:0]   frame_height_r;
  logic [CW-1:0]     col_count_r;
  logic [FH_W-1:0]   row_count_r;
  logic [WW-1:0]     fw_ext;
  logic [WW-1:0]     w_use;
  logic [FH_W-1:0]   h_use;
  logic              row_end;
  logic              frame_end;
  logic              advance;
  logic              accept;
  meta_t             meta_nxt;

  logic              valid_a_r;
  logic [PIX_W-1:0]  pix_a_r;
  logic [CW-1:0]     col_a_r;
  meta_t             meta_a_r;
  logic [PIX_W-1:0]  top_a;
  logic [PIX_W-1:0]  mid_a;

  logic              valid_c;
  meta_t             meta_c;
  logic [GRAD_W-1:0] abs_gx_c;
  logic [GRAD_W-1:0] abs_gy_c;

  logic              valid_d_r;
  meta_t             meta_d_r;
  logic [SQ_W-1:0]   sq_x_d_r;
  logic [SQ_W-1:0]   sq_y_d_r;
  logic              valid_e_r;
  meta_t             meta_e_r;
  logic [ENERGY_W-1:0] energy_e_r;

  sqrt_beat_t        sqrt_head;
  sqrt_beat_t        chain [SQRT_STEPS+1];

  logic              out_valid_r;
  meta_t             out_meta_r;
  logic [ROOT_W-1:0] out_mag_r;

  assign advance  = !out_valid_r || !out_stall;
  assign accept   = in_valid && advance;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = WW'(frame_width_r);
    if (fw_ext < WW'(MIN_DIM)) begin
      w_use = WW'(MIN_DIM);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = fw_ext;
    end
    h_use = (frame_height_r < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height_r;
    row_end   = (WW'(col_count_r) + WW'(1)) >= w_use;
    frame_end = ({1'b0, row_count_r} + 17'd1) >= {1'b0, h_use};
    meta_nxt.emit = (row_count_r >= FH_W'(2)) && (col_count_r >= CW'(2));
    meta_nxt.last = row_end && frame_end;
    meta_nxt.row  = row_count_r - FH_W'(1);
    meta_nxt.col  = OUT_COL_W'(col_count_r - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      valid_a_r   <= 1'b0;
      valid_d_r   <= 1'b0;
      valid_e_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (row_end) begin
          col_count_r <= '0;
          row_count_r <= frame_end ? '0 : row_count_r + FH_W'(1);
        end else begin
          col_count_r <= col_count_r + CW'(1);
        end
      end
      if (advance) begin
        valid_a_r   <= in_valid;
        valid_d_r   <= valid_c;
        valid_e_r   <= valid_d_r;
        out_valid_r <= chain[SQRT_STEPS].valid && chain[SQRT_STEPS].meta.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_a_r  <= in_pixel_value;
      col_a_r  <= col_count_r;
      meta_a_r <= meta_nxt;
    end
    if (advance) begin
      meta_d_r   <= meta_c;
      sq_x_d_r   <= SQ_W'(abs_gx_c) * SQ_W'(abs_gx_c);
      sq_y_d_r   <= SQ_W'(abs_gy_c) * SQ_W'(abs_gy_c);
      meta_e_r   <= meta_d_r;
      energy_e_r <= ENERGY_W'(sq_x_d_r) + ENERGY_W'(sq_y_d_r);
      out_meta_r <= chain[SQRT_STEPS].meta;
      out_mag_r  <= chain[SQRT_STEPS].sat ? MAG_SAT : chain[SQRT_STEPS].root;
    end
  end

  sem_line_store #(
    .MAX_WIDTH(MAX_WIDTH),
    .AW       (CW)
  ) u_line_store (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(col_count_r),
    .wr_en  (advance && valid_a_r),
    .wr_addr(col_a_r),
    .wr_pix (pix_a_r),
    .top    (top_a),
    .mid    (mid_a)
  );

  sem_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .valid_in (valid_a_r),
    .meta_in  (meta_a_r),
    .top      (top_a),
    .mid      (mid_a),
    .pix      (pix_a_r),
    .valid_out(valid_c),
    .meta_out (meta_c),
    .abs_gx   (abs_gx_c),
    .abs_gy   (abs_gy_c)
  );

  always_comb begin
    sqrt_head.valid = valid_e_r;
    sqrt_head.meta  = meta_e_r;
    sqrt_head.sat   = energy_e_r[ENERGY_W-1:RAD_W] != '0;
    sqrt_head.rad   = energy_e_r[RAD_W-1:0];
    sqrt_head.rem   = '0;
    sqrt_head.root  = '0;
  end

  assign chain[0] = sqrt_head;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    sem_sqrt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (advance),
      .d_in (chain[g]),
      .d_out(chain[g+1])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_row            = out_meta_r.row;
  assign out_col            = out_meta_r.col;
  assign out_edge_magnitude = out_mag_r;
  assign out_frame_last     = out_meta_r.last;

endmodule
